// ----- sv/overwriting_sample_history_ring_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the overwriting sample history ring
// Shared helpers that write a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_SAMPLE_HISTORY_RING_MACROS_SVH
`define OVERWRITING_SAMPLE_HISTORY_RING_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OSHR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define OSHR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/oshr_pkg.sv -----
// ----------------------------------------------------------------------------
// oshr_pkg
// Sizes, function codes, result types and helpers of the sample history ring.
// ----------------------------------------------------------------------------
package oshr_pkg;

   // Store geometry and field widths.
   localparam int DEPTH     = 65536;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int SAMPLE_W  = 16;
   localparam int MAX_BURST = 64;
   localparam int BURST_W   = $clog2(MAX_BURST + 1);

   // Function codes of a request.
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_QUERY = 2'd3;

   // Descriptor of one pending response, ahead of the output register.
   typedef struct packed {
      logic             is_read;
      logic             status;
      logic             last;
      logic [CNT_W-1:0] count;
   } rsp_meta_type;

   // Clamp a written capacity into the range one to DEPTH.
   function automatic logic [CNT_W-1:0] eff_capacity(input logic [CNT_W-1:0] raw);
      logic [CNT_W-1:0] cap;
      cap = raw;
      if (raw == '0) begin
         cap = CNT_W'(1);
      end else if (raw > CNT_W'(DEPTH)) begin
         cap = CNT_W'(DEPTH);
      end
      return cap;
   endfunction

endpackage

// ----- sv/overwriting_sample_history_ring.sv -----
// ----------------------------------------------------------------------------
// overwriting_sample_history_ring
// Keeps the most recent audio samples in a single-port-write, registered-read
// memory of 64K entries, with a usable capacity set by a control register.
// Once the capacity is reached, each new sample replaces the oldest one.
// A write, clear or count query gives one response; a new request can be
// taken while that response waits in the output register. A read burst
// works out the start address in its check, base and start states (empty
// check, clip and oldest entry, offset wrap), then reads one sample per cycle
// on the memory read port while the response stage has room. The request
// port stays held until the last read of the burst is issued; an empty read
// answers from the check state. Writing the capacity register also empties
// the ring. No reset clearing pass is needed: entries are read only once written.
// ----------------------------------------------------------------------------
module overwriting_sample_history_ring
   import oshr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [ADDR_W-1:0]          req_read_offset,
   input  logic [BURST_W-1:0]         req_burst_length,
   // Response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_status,
   output logic                       rsp_last,
   output logic [CNT_W-1:0]           rsp_stored_count,
   // Capacity register write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CNT_W-1:0]           csr_capacity_in_use
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BASE,
      ST_START,
      ST_BURST
   } state_type;

   // Sample memory and its registered read data.
   logic [SAMPLE_W-1:0] sample_store [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // Control registers and their next values.
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [ADDR_W-1:0]  offset_ff, offset_in;
   logic [BURST_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0]   diff_ff, diff_in;
   logic [CNT_W:0]     base_ff, base_in;
   logic [BURST_W-1:0] nleft_ff, nleft_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;

   // Pending response stage and output register.
   logic               s1_valid_ff, s1_valid_in;
   rsp_meta_type       s1_meta_ff, s1_meta_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Handshake helpers and memory controls.
   logic               out_free;
   logic               s1_free;
   logic               load_s1;
   rsp_meta_type       load_meta;
   logic               mem_we;
   logic               mem_re;
   logic [CNT_W-1:0]   wp_inc;
   logic [CNT_W-1:0]   pos_inc;
   logic [CNT_W:0]     start_sum;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && s1_free && !csr_valid;

   assign wp_inc    = CNT_W'(wp_ff) + CNT_W'(1);
   assign pos_inc   = pos_ff + CNT_W'(1);
   assign start_sum = {1'b0, pos_ff} + (CNT_W + 1)'(offset_ff);

   // Sequencer: request decode, burst address setup and burst issue.
   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      held_in   = held_ff;
      cap_in    = cap_ff;
      offset_in = offset_ff;
      len_in    = len_ff;
      diff_in   = diff_ff;
      base_in   = base_ff;
      nleft_in  = nleft_ff;
      pos_in    = pos_ff;
      load_s1   = 1'b0;
      load_meta = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               // A capacity change always empties the ring.
               cap_in  = eff_capacity(csr_capacity_in_use);
               wp_in   = '0;
               held_in = '0;
            end else if (req_valid && req_ready) begin
               case (req_func)
                  FUNC_WRITE: begin
                     mem_we  = 1'b1;
                     wp_in   = (wp_inc == cap_ff) ? '0 : wp_inc[ADDR_W-1:0];
                     held_in = (held_ff < cap_ff) ? held_ff + CNT_W'(1) : held_ff;
                     load_s1         = 1'b1;
                     load_meta.last  = 1'b1;
                     load_meta.count = held_in;
                  end
                  FUNC_READ: begin
                     offset_in = req_read_offset;
                     len_in    = (req_burst_length > BURST_W'(MAX_BURST)) ?
                                 BURST_W'(MAX_BURST) : req_burst_length;
                     state_in  = ST_CHECK;
                  end
                  FUNC_CLEAR: begin
                     wp_in           = '0;
                     held_in         = '0;
                     load_s1         = 1'b1;
                     load_meta.last  = 1'b1;
                     load_meta.count = held_ff;
                  end
                  default: begin
                     load_s1         = 1'b1;
                     load_meta.last  = 1'b1;
                     load_meta.count = held_ff;
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if (len_ff == '0 || CNT_W'(offset_ff) >= held_ff) begin
               // Nothing to read: one response flagged with status.
               if (s1_free) begin
                  load_s1          = 1'b1;
                  load_meta.status = 1'b1;
                  load_meta.last   = 1'b1;
                  load_meta.count  = held_ff;
                  state_in         = ST_IDLE;
               end
            end else begin
               diff_in  = held_ff - CNT_W'(offset_ff);
               base_in  = {1'b0, CNT_W'(wp_ff)} + {1'b0, cap_ff} - {1'b0, held_ff};
               state_in = ST_BASE;
            end
         end

         ST_BASE: begin
            // Clip the burst and wrap the oldest entry into the ring.
            nleft_in = (diff_ff < CNT_W'(len_ff)) ? diff_ff[BURST_W-1:0] : len_ff;
            pos_in   = (base_ff >= {1'b0, cap_ff}) ?
                       CNT_W'(base_ff - {1'b0, cap_ff}) : CNT_W'(base_ff);
            state_in = ST_START;
         end

         ST_START: begin
            pos_in   = (start_sum >= {1'b0, cap_ff}) ?
                       CNT_W'(start_sum - {1'b0, cap_ff}) : CNT_W'(start_sum);
            state_in = ST_BURST;
         end

         ST_BURST: begin
            // One memory read per cycle while the response stage has room.
            if (s1_free) begin
               mem_re            = 1'b1;
               load_s1           = 1'b1;
               load_meta.is_read = 1'b1;
               load_meta.last    = (nleft_ff == BURST_W'(1));
               load_meta.count   = held_ff;
               pos_in            = (pos_inc == cap_ff) ? '0 : pos_inc;
               nleft_in          = nleft_ff - BURST_W'(1);
               if (nleft_ff == BURST_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response pipeline: the pending stage feeds the output register.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_meta_in    = s1_meta_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;

      if (out_free) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_sample_in = s1_meta_ff.is_read ? rd_data_ff : '0;
         rsp_status_in = s1_meta_ff.status;
         rsp_last_in   = s1_meta_ff.last;
         rsp_count_in  = s1_meta_ff.count;
         s1_valid_in   = 1'b0;
      end
      if (load_s1) begin
         s1_valid_in = 1'b1;
         s1_meta_in  = load_meta;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         held_ff      <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         held_ff       <= held_in;
         cap_ff        <= cap_in;
         offset_ff     <= offset_in;
         len_ff        <= len_in;
         diff_ff       <= diff_in;
         base_ff       <= base_in;
         nleft_ff      <= nleft_in;
         pos_ff        <= pos_in;
         s1_valid_ff   <= s1_valid_in;
         s1_meta_ff    <= s1_meta_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_sample_ff <= rsp_sample_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   // Sample memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store[wp_ff] <= req_sample_in;
      end
      if (mem_re) begin
         rd_data_ff <= sample_store[pos_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_out   = rsp_sample_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_stored_count = rsp_count_ff;

endmodule

// ----- sv/oshr_checker.sv -----
// ----------------------------------------------------------------------------
// oshr_checker
// Port-level checks on the sample history ring, bound to its top level.
// ----------------------------------------------------------------------------
`include "overwriting_sample_history_ring_macros.svh"

module oshr_checker
   import oshr_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_status,
   input logic                       rsp_last,
   input logic [CNT_W-1:0]           rsp_stored_count
);

   // Shape of an empty read response, and a stalled non-final burst response.
   logic empty_rsp_ok;
   logic burst_held;

   assign empty_rsp_ok = rsp_last && (rsp_sample_out == '0);
   assign burst_held   = rsp_valid && !rsp_last && !rsp_ready;

   // A response transaction stays offered until it is taken.
   `OSHR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

   // An empty read always ends its burst and carries no sample.
   `OSHR_ASSERT_SAME(a_empty_read, rsp_valid && rsp_status, empty_rsp_ok, "bad empty read")

   // The reported count never exceeds the store depth.
   `OSHR_ASSERT_SAME(a_count_range, rsp_valid, rsp_stored_count <= CNT_W'(DEPTH), "count too high")

   // No new request is taken while a non-final burst response is stalled.
   `OSHR_ASSERT_SAME(a_burst_busy, burst_held, !req_ready, "request taken inside a burst")

endmodule

bind overwriting_sample_history_ring oshr_checker u_oshr_checker (.*);
